// ===== rtl/core/hcfm_pkg.sv =====
package hcfm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int COUNT_W    = 11;
  localparam int RATE_W     = 23;
  localparam int FREQ_W     = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // block length must stay a power of two: the divisor 2^n - 1 is folded
  localparam int BLOCK_SAMPLES = 2048;
  localparam int POS_W         = $clog2(BLOCK_SAMPLES);
  localparam int DEN           = BLOCK_SAMPLES - 1;

  // q8 scaling over twice the span: 256 / 2
  localparam int FRAC_SHIFT = 7;
  localparam int MUL_W      = RATE_W + COUNT_W;
  localparam int PROD_W     = MUL_W + FRAC_SHIFT;
  localparam int FOLD_A_W   = PROD_W - POS_W;
  localparam int FOLD_STEPS = 4;
  localparam int FOLD_W     = $clog2(FOLD_STEPS);

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [SAMPLE_W-1:0] HIGH_RESET = SAMPLE_W'(2248);
  localparam logic [SAMPLE_W-1:0] LOW_RESET  = SAMPLE_W'(1848);
  localparam logic [RATE_W-1:0]   RATE_RESET = RATE_W'(1000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH = 2'd0,
    REG_LOW  = 2'd1,
    REG_RATE = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/core/hcfm_if.sv =====
interface hcfm_in_if;
  import hcfm_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface hcfm_out_if;
  import hcfm_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] crossing_count;
  logic [FREQ_W-1:0]  frequency_q8;

  modport source (output valid, output crossing_count, output frequency_q8, input ready);
  modport sink (input valid, input crossing_count, input frequency_q8, output ready);
endinterface

// ===== rtl/core/hysteresis_crossing_frequency_meter.sv =====
// Hysteresis crossing frequency meter: takes one 12-bit ADC sample per transaction in
// blocks of 2048 and, after the last sample of a block, returns the number of hysteresis
// crossings in it and the frequency in Q8 hertz, rate * count * 128 / 2047, truncated.
// One sample is accepted in every cycle unless the input stalls; samples are registered
// and the crossing state is updated in the next cycle. A small sequencer (one multiply,
// four folds by 2^11 - 1, one correction) works out the frequency; the input stalls only
// if a block's last sample arrives while the previous block's result is still in that
// sequencer. The result register holds one result until it is taken. Thresholds and rate
// must be written by the user through the cfg port while idle; the block does not enforce it.
module hysteresis_crossing_frequency_meter (
  input  logic                             clk,
  input  logic                             rst_n,
  hcfm_in_if.sink                          in_ch,
  hcfm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [hcfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcfm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hcfm_pkg::*;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_FOLD,
    U_FIX,
    U_DONE
  } fstate_t;

  logic [SAMPLE_W-1:0] high_r;
  logic [SAMPLE_W-1:0] low_r;
  logic [RATE_W-1:0]   rate_r;

  logic [POS_W-1:0]    pos_r;
  logic                in_first;
  logic                in_last;
  logic                in_acc;

  logic                s1_valid_r;
  logic                s1_first_r;
  logic                s1_last_r;
  logic [SAMPLE_W-1:0] s1_sample_r;

  logic [SAMPLE_W-1:0] prev_r;
  logic                from_high_r;
  logic                from_low_r;
  logic [COUNT_W-1:0]  cross_r;

  logic                hit;
  logic                from_high_nxt;
  logic                from_low_nxt;
  logic [COUNT_W-1:0]  cross_nxt;

  fstate_t             fst_r;
  logic [COUNT_W-1:0]  ucnt_r;
  logic [RATE_W-1:0]   urate_r;
  logic [PROD_W-1:0]   n_r;
  logic [FREQ_W-1:0]   q_r;
  logic [FOLD_W-1:0]   fold_r;
  logic [MUL_W-1:0]    mul_w;
  logic [FOLD_A_W-1:0] fold_a;
  logic [PROD_W-1:0]   n_fold;

  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [FREQ_W-1:0]   out_freq_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r <= HIGH_RESET;
      low_r  <= LOW_RESET;
      rate_r <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH: high_r <= cfg_wdata[SAMPLE_W-1:0];
        REG_LOW:  low_r  <= cfg_wdata[SAMPLE_W-1:0];
        REG_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // input side: position in block and input register
  assign in_first = (pos_r == '0);
  assign in_last  = (pos_r == POS_W'(BLOCK_SAMPLES - 1));
  // a last sample needs the frequency sequencer free when it reaches it
  assign in_ch.ready = !(in_last && ((fst_r != U_IDLE) || (s1_valid_r && s1_last_r)));
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        pos_r <= in_last ? '0 : pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_ch.sample;
      s1_first_r  <= in_first;
      s1_last_r   <= in_last;
    end
  end

  // crossing rules, first match wins
  always_comb begin
    hit           = 1'b0;
    from_high_nxt = from_high_r;
    from_low_nxt  = from_low_r;
    if (!s1_first_r) begin
      if (s1_sample_r > high_r && prev_r < low_r) begin
        hit = 1'b1;
      end else if (s1_sample_r < low_r && prev_r > high_r) begin
        hit = 1'b1;
      end else if (!from_high_r && !from_low_r && s1_sample_r < high_r
                   && s1_sample_r > low_r) begin
        if (prev_r > high_r) begin
          from_high_nxt = 1'b1;
        end else if (prev_r < low_r) begin
          from_low_nxt = 1'b1;
        end
      end else if (from_high_r && s1_sample_r < low_r) begin
        hit           = 1'b1;
        from_high_nxt = 1'b0;
      end else if (from_low_r && s1_sample_r > high_r) begin
        hit          = 1'b1;
        from_low_nxt = 1'b0;
      end
    end
    // saturating count
    cross_nxt = (hit && cross_r != COUNT_MAX) ? cross_r + COUNT_W'(1) : cross_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      from_high_r <= 1'b0;
      from_low_r  <= 1'b0;
      cross_r     <= '0;
    end else if (s1_valid_r) begin
      if (s1_last_r) begin
        prev_r      <= '0;
        from_high_r <= 1'b0;
        from_low_r  <= 1'b0;
        cross_r     <= '0;
      end else begin
        prev_r      <= s1_sample_r;
        from_high_r <= from_high_nxt;
        from_low_r  <= from_low_nxt;
        cross_r     <= cross_nxt;
      end
    end
  end

  // frequency: n = rate * count * 128, q = n / (2^POS_W - 1)
  // fold step: n = a * 2^POS_W + b gives q += a, n = a + b
  assign mul_w  = urate_r * ucnt_r;
  assign fold_a = n_r[PROD_W-1:POS_W];
  assign n_fold = PROD_W'(fold_a) + PROD_W'(n_r[POS_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r       <= U_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (fst_r)
        U_IDLE: begin
          if (s1_valid_r && s1_last_r) begin
            ucnt_r  <= cross_nxt;
            urate_r <= rate_r;
            fst_r   <= U_MUL;
          end
        end
        U_MUL: begin
          n_r    <= {mul_w, {FRAC_SHIFT{1'b0}}};
          q_r    <= '0;
          fold_r <= '0;
          fst_r  <= U_FOLD;
        end
        U_FOLD: begin
          n_r    <= n_fold;
          q_r    <= q_r + fold_a[FREQ_W-1:0];
          fold_r <= fold_r + FOLD_W'(1);
          if (fold_r == FOLD_W'(FOLD_STEPS - 1)) begin
            fst_r <= U_FIX;
          end
        end
        U_FIX: begin
          // after the folds the remainder is at most 2^POS_W
          if (n_r >= PROD_W'(DEN)) begin
            q_r <= q_r + FREQ_W'(1);
          end
          fst_r <= U_DONE;
        end
        U_DONE: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_count_r <= ucnt_r;
            out_freq_r  <= q_r;
            fst_r       <= U_IDLE;
          end
        end
        default: fst_r <= U_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.crossing_count = out_count_r;
  assign out_ch.frequency_q8   = out_freq_r;

endmodule

// ===== rtl/core/hcfm_checker.sv =====
module hcfm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [hcfm_pkg::COUNT_W-1:0]   out_count,
  input logic [hcfm_pkg::FREQ_W-1:0]    out_freq
);
  import hcfm_pkg::*;

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_freq))
    else $error("result changed while stalled");

  // no crossings means no frequency
  a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count == '0 |-> out_freq == '0)
    else $error("nonzero frequency with zero crossings");

  // a waiting result loads only once the result register is empty, so a taken result is never followed at once
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("back to back results");

  // an offered sample always sees a defined ready
  a_in_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_ready))
    else $error("input ready unknown");

endmodule

bind hysteresis_crossing_frequency_meter hcfm_checker u_hcfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.crossing_count),
  .out_freq  (out_ch.frequency_q8)
);

// ===== sim/tb_top.sv =====
module tb_top;
  import hcfm_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE       = 16;
  localparam int HOLD_CYCLES  = 8000;
  localparam int RANDOM_BLOCKS  = 40;
  localparam int STEADY_BLOCK   = 6;
  localparam int PRESSURE_BLOCK = 12;
  localparam int IDLE_PCT       = 6;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int PLAN_ROWS      = 13;

  // no register lives at this index, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [RATE_W-1:0]    RATE_TOP  = {RATE_W{1'b1}};

  typedef struct packed {
    logic [COUNT_W-1:0] crossing_count;
    logic [FREQ_W-1:0]  frequency_q8;
  } reading_t;

  typedef enum {RGN_BELOW, RGN_RISE, RGN_ABOVE, RGN_FALL} region_t;
  typedef enum {SRC_WAVE, SRC_EDGE, SRC_NOISE} source_t;

  typedef struct {
    bit                       write_cfg;
    logic [CFG_DATA_W-1:0]    hi_w;
    logic [CFG_DATA_W-1:0]    lo_w;
    logic [CFG_DATA_W-1:0]    rate_w;
    logic [3:0][SAMPLE_W-1:0] pat;
    int                       pat_len;
    bit                       typed;
    logic [COUNT_W-1:0]       exp_count;
    logic [FREQ_W-1:0]        exp_freq;
  } plan_row_t;

  // one block per row, pattern repeated over the block, first listed sample first
  plan_row_t plan [PLAN_ROWS] = '{
    '{1'b0, 23'd0, 23'd0, 23'd0, {12'd0, 12'd0, 12'd0, 12'd0}, 1,
      1'b1, 11'd0, 30'd0},
    '{1'b1, 23'd2248, 23'd1848, 23'd5000000, {12'd0, 12'd4095, 12'd0, 12'd0}, 2,
      1'b1, 11'd2047, 30'd640000000},
    '{1'b1, 23'd2248, 23'd1848, 23'd8388607, {12'd4095, 12'd0, 12'd0, 12'd0}, 2,
      1'b1, 11'd2047, 30'd1073741696},
    '{1'b1, 23'd2248, 23'd1848, 23'd0, {12'd0, 12'd4095, 12'd0, 12'd0}, 2,
      1'b1, 11'd2047, 30'd0},
    '{1'b1, 23'd4095, 23'd0, 23'd1000000, {12'd0, 12'd4095, 12'd0, 12'd0}, 2,
      1'b1, 11'd0, 30'd0},
    '{1'b1, 23'd2248, 23'd1848, 23'd1, {12'd2248, 12'd1848, 12'd0, 12'd0}, 2,
      1'b1, 11'd0, 30'd0},
    '{1'b1, 23'd2248, 23'd1848, 23'd1, {12'd2249, 12'd1847, 12'd0, 12'd0}, 2,
      1'b1, 11'd2047, 30'd128},
    '{1'b1, 23'd2248, 23'd1848, 23'd1000000, {12'd0, 12'd2000, 12'd4095, 12'd2000}, 4,
      1'b0, 11'd0, 30'd0},
    '{1'b1, 23'd2248, 23'd1848, 23'd3000000, {12'd4095, 12'd2048, 12'd2048, 12'd0}, 4,
      1'b0, 11'd0, 30'd0},
    '{1'b1, 23'd1000, 23'd3000, 23'd48000, {12'd0, 12'd2000, 12'd4095, 12'd2000}, 4,
      1'b0, 11'd0, 30'd0},
    '{1'b1, 23'd2048, 23'd2048, 23'd777777, {12'd2047, 12'd2048, 12'd2049, 12'd2048}, 4,
      1'b0, 11'd0, 30'd0},
    '{1'b1, 23'd0, 23'd4095, 23'd1, {12'd4095, 12'd0, 12'd2048, 12'd0}, 3,
      1'b0, 11'd0, 30'd0},
    // upper data bits set on the threshold writes, they must be dropped
    '{1'b1, 23'h7FF8C8, 23'h7FF738, 23'd1000000, {12'd0, 12'd4095, 12'd0, 12'd0}, 2,
      1'b1, 11'd2047, 30'd128000000}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  hcfm_in_if  in_if ();
  hcfm_out_if out_if ();

  hysteresis_crossing_frequency_meter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies as the meter should hold them
  logic [SAMPLE_W-1:0] thr_high = HIGH_RESET;
  logic [SAMPLE_W-1:0] thr_low  = LOW_RESET;
  logic [RATE_W-1:0]   rate_hz  = RATE_RESET;

  // crossing tracker state
  logic [SAMPLE_W-1:0] trk_prev = '0;
  bit                  trk_from_high = 1'b0;
  bit                  trk_from_low = 1'b0;
  logic [COUNT_W-1:0]  trk_count = '0;
  int                  trk_pos = 0;

  reading_t readings_due[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       in_idle_pct = IDLE_PCT;
  int       out_idle_pct = IDLE_PCT;
  int       pressure_req = 0;
  int       pressure_seen = 0;
  int       hold_left = 0;

  region_t gen_region = RGN_BELOW;
  int      gen_dwell = 0;

  function automatic void count_crossing();
    if (trk_count != COUNT_MAX) trk_count++;
  endfunction

  // advance the crossing tracker by one sample, returns 1 when a block closes
  function automatic bit track_crossing(input logic [SAMPLE_W-1:0] s, output reading_t r);
    logic [SAMPLE_W-1:0] p;
    longint unsigned     scaled;
    p = trk_prev;
    r = '0;
    if (trk_pos != 0) begin
      if (s > thr_high && p < thr_low) begin
        count_crossing();
      end else if (s < thr_low && p > thr_high) begin
        count_crossing();
      end else if (!trk_from_high && !trk_from_low && s < thr_high && s > thr_low) begin
        if (p > thr_high) trk_from_high = 1'b1;
        else if (p < thr_low) trk_from_low = 1'b1;
      end else if (trk_from_high && s < thr_low) begin
        count_crossing();
        trk_from_high = 1'b0;
      end else if (trk_from_low && s > thr_high) begin
        count_crossing();
        trk_from_low = 1'b0;
      end
    end
    trk_prev = s;
    if (trk_pos == BLOCK_SAMPLES - 1) begin
      scaled = longint'(rate_hz) * longint'(trk_count) * 128;
      r.crossing_count = trk_count;
      r.frequency_q8 = FREQ_W'(scaled / DEN);
      trk_prev = '0;
      trk_from_high = 1'b0;
      trk_from_low = 1'b0;
      trk_count = '0;
      trk_pos = 0;
      return 1'b1;
    end
    trk_pos++;
    return 1'b0;
  endfunction

  function automatic int in_range(input int a, input int b);
    if (a > b) return $urandom_range(0, SAMPLE_MAX);
    return $urandom_range(b, a);
  endfunction

  function automatic logic [SAMPLE_W-1:0] next_sample(input source_t src);
    int lo;
    int hi;
    int v;
    lo = thr_low;
    hi = thr_high;
    case (src)
      SRC_NOISE: begin
        v = $urandom_range(0, SAMPLE_MAX);
      end
      SRC_EDGE: begin
        case ($urandom_range(0, 7))
          0: v = lo - 1;
          1: v = lo;
          2: v = lo + 1;
          3: v = hi - 1;
          4: v = hi;
          5: v = hi + 1;
          6: v = 0;
          default: v = SAMPLE_MAX;
        endcase
      end
      default: begin
        // walk below -> band -> above -> band with random dwell, sometimes jumping the band
        // or turning back inside it
        if (gen_dwell == 0) begin
          case (gen_region)
            RGN_BELOW: gen_region = ($urandom_range(0, 9) < 3) ? RGN_ABOVE : RGN_RISE;
            RGN_RISE:  gen_region = ($urandom_range(0, 19) < 3) ? RGN_BELOW : RGN_ABOVE;
            RGN_ABOVE: gen_region = ($urandom_range(0, 9) < 3) ? RGN_BELOW : RGN_FALL;
            default:   gen_region = ($urandom_range(0, 19) < 3) ? RGN_ABOVE : RGN_BELOW;
          endcase
          gen_dwell = $urandom_range(1, 6);
        end
        gen_dwell--;
        if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? hi : lo;
        else if (gen_region == RGN_BELOW) v = in_range(0, lo - 1);
        else if (gen_region == RGN_ABOVE) v = in_range(hi + 1, SAMPLE_MAX);
        else v = in_range(lo + 1, hi - 1);
      end
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic program_meter(input logic [CFG_DATA_W-1:0] hi_w, lo_w, rate_w);
    cfg_we <= 1'b1;
    cfg_index <= REG_HIGH;
    cfg_wdata <= hi_w;
    @(posedge clk);
    cfg_index <= REG_LOW;
    cfg_wdata <= lo_w;
    @(posedge clk);
    cfg_index <= REG_RATE;
    cfg_wdata <= rate_w;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_high = hi_w[SAMPLE_W-1:0];
    thr_low = lo_w[SAMPLE_W-1:0];
    rate_hz = rate_w[RATE_W-1:0];
  endtask

  // stop offering samples and wait until every expected result is out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input reading_t typed_r);
    reading_t r;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    if (track_crossing(s, r)) readings_due.push_back(typed ? typed_r : r);
  endtask

  task automatic program_random();
    int hi;
    int lo;
    int k;
    logic [RATE_W-1:0] rate;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      lo = $urandom_range(0, 3900);
      hi = lo + $urandom_range(2, 190);
    end else if (k == 7) begin
      hi = $urandom_range(0, 2047);
      lo = $urandom_range(2048, SAMPLE_MAX);
    end else begin
      hi = $urandom_range(0, SAMPLE_MAX);
      lo = $urandom_range(0, SAMPLE_MAX);
    end
    k = $urandom_range(0, 9);
    if (k == 0) rate = '0;
    else if (k == 1) rate = RATE_TOP;
    else if (k == 2) rate = RATE_W'(1);
    else rate = RATE_W'($urandom_range(1, 5000000));
    program_meter({11'($urandom), SAMPLE_W'(hi)}, {11'($urandom), SAMPLE_W'(lo)}, rate);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // result side: random stalls, plus one long hold-off so the meter backs up
  always @(posedge clk) begin
    if (pressure_req != pressure_seen) begin
      pressure_seen <= pressure_req;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (readings_due.size() == 0) begin
        $error("unexpected transaction: crossing_count %0d, frequency_q8 %0d",
               out_if.crossing_count, out_if.frequency_q8);
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        if (out_if.crossing_count !== want.crossing_count) begin
          $error("crossing_count: expected %0d, got %0d",
                 want.crossing_count, out_if.crossing_count);
          mismatches++;
        end
        if (out_if.frequency_q8 !== want.frequency_q8) begin
          $error("frequency_q8: expected %0d, got %0d",
                 want.frequency_q8, out_if.frequency_q8);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** hysteresis_crossing_frequency_meter: FAILED **");
      $finish;
    end
  end

  initial begin
    reading_t typed_r;
    source_t  src;
    int       k;
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    foreach (plan[row]) begin
      if (plan[row].write_cfg) begin
        wait_drained();
        program_meter(plan[row].hi_w, plan[row].lo_w, plan[row].rate_w);
      end
      typed_r.crossing_count = plan[row].exp_count;
      typed_r.frequency_q8 = plan[row].exp_freq;
      for (int i = 0; i < BLOCK_SAMPLES; i++)
        send_sample(plan[row].pat[3 - (i % plan[row].pat_len)], plan[row].typed, typed_r);
    end

    typed_r = '0;
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      // keep streaming through the blocks behind the hold-off so the input stalls
      if (b == 0 || (!(b > PRESSURE_BLOCK && b <= PRESSURE_BLOCK + 2)
                     && $urandom_range(0, 2) == 0)) begin
        wait_drained();
        program_random();
      end
      in_idle_pct = (b == STEADY_BLOCK) ? 0 : IDLE_PCT;
      out_idle_pct = (b == STEADY_BLOCK) ? 0 : IDLE_PCT;
      if (b == PRESSURE_BLOCK) pressure_req <= pressure_req + 1;
      k = $urandom_range(0, 9);
      src = (k < 6) ? SRC_WAVE : (k < 8) ? SRC_EDGE : SRC_NOISE;
      gen_region = region_t'($urandom_range(0, 3));
      gen_dwell = 0;
      for (int i = 0; i < BLOCK_SAMPLES; i++)
        send_sample(next_sample(src), 1'b0, typed_r);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("** hysteresis_crossing_frequency_meter: PASSED **");
    end else begin
      $display("** hysteresis_crossing_frequency_meter: FAILED **");
    end
    $finish;
  end

endmodule
